[design/msb_first_bit_field_packer_unit_macros.svh]
// Assertion macros for the MSB-first bit field packer.
`ifndef MSB_FIRST_BIT_FIELD_PACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MFBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MFBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/mfbp_pkg.sv]
// Shared types and constants for the MSB-first bit field packer.
package mfbp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int MODE_W             = 2;
    localparam int WIDTH_W            = 6;
    localparam int VALUE_W            = 32;
    localparam int BYTE_W             = 8;
    localparam int BPOS_W             = 3;
    localparam int IN_DATA_W          = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_UNSIGNED = 2'd0,
        MODE_SIGNED   = 2'd1,
        MODE_FLUSH    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [BPOS_W-1:0] bit_pos;
        logic [BYTE_W-1:0] partial;
    } t_pack_state;

endpackage

[design/mfbp_packer.sv]
// Combinational field merge: partial byte plus one field into completed bytes.
module mfbp_packer #(
    parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS_DEF,
    localparam int LIMIT = (MAX_FIELD_BITS < mfbp_pkg::VALUE_W) ?
                           MAX_FIELD_BITS : mfbp_pkg::VALUE_W,
    localparam int NB    = (LIMIT + 7) / 8,
    localparam int CNT_W = $clog2(NB + 1)
) (
    input  mfbp_pkg::t_mode                          i_mode,
    input  logic [mfbp_pkg::WIDTH_W-1:0]             i_width,
    input  logic [mfbp_pkg::VALUE_W-1:0]             i_value,
    input  mfbp_pkg::t_pack_state                    i_state,
    output mfbp_pkg::t_pack_state                    o_state,
    output logic [CNT_W-1:0]                         o_count,
    output logic [NB-1:0][mfbp_pkg::BYTE_W-1:0]      o_bytes
);
    import mfbp_pkg::*;

    localparam int ACC_W = BYTE_W * (NB + 1);
    localparam int SH_W  = $clog2(ACC_W + 1);
    localparam int TOT_W = $clog2(ACC_W);

    logic [WIDTH_W-1:0]       w_sat;
    logic [VALUE_W-1:0]       masked;
    logic [ACC_W+VALUE_W-1:0] wide;
    logic [ACC_W+VALUE_W-1:0] shifted;
    logic [SH_W-1:0]          shamt;
    logic [ACC_W-1:0]         acc;
    logic [TOT_W-1:0]         total;
    logic [CNT_W-1:0]         nbytes;
    logic [BYTE_W-1:0]        next_partial;

    always_comb begin
        w_sat   = (i_width > WIDTH_W'(LIMIT)) ? WIDTH_W'(LIMIT) : i_width;
        masked  = i_value & ~({VALUE_W{1'b1}} << w_sat);
        wide    = {{ACC_W{1'b0}}, masked};
        shamt   = SH_W'(ACC_W) - SH_W'(i_state.bit_pos) - SH_W'(w_sat);
        shifted = wide << shamt;
        acc     = {i_state.partial, {(ACC_W-BYTE_W){1'b0}}} | shifted[ACC_W-1:0];
        total   = TOT_W'(i_state.bit_pos) + TOT_W'(w_sat);
        nbytes  = CNT_W'(total >> 3);
        next_partial = acc[ACC_W-1-BYTE_W*int'(nbytes) -: BYTE_W];
    end

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            o_bytes[k] = acc[ACC_W-1-BYTE_W*k -: BYTE_W];
        end
        o_state = i_state;
        o_count = '0;
        case (i_mode)
            MODE_UNSIGNED, MODE_SIGNED: begin
                if (!(i_mode == MODE_SIGNED && w_sat < WIDTH_W'(2))) begin
                    o_count         = nbytes;
                    o_state.bit_pos = total[BPOS_W-1:0];
                    o_state.partial = next_partial;
                end
            end
            MODE_FLUSH: begin
                o_bytes[0] = i_state.partial;
                if (i_state.bit_pos != '0) begin
                    o_count = CNT_W'(1);
                    o_state = '0;
                end
            end
            default: begin
                o_count = '0;
            end
        endcase
    end

endmodule

[design/msb_first_bit_field_packer_unit.sv]
// Top level of the MSB-first bit field packer: input register, merge, byte buffer.
//
// Usage:
//   s_axis carries one field request per beat: mode, width and value. Modes are
//   unsigned field, signed field (widths below 2 write nothing) and flush, which
//   pads a pending partial byte with zeros. Widths above the field limit
//   saturate. m_axis carries the completed bytes, first written bit in bit 7;
//   m_axis_tlast marks the final byte caused by a request.
// Order: an accepted request waits in the input register until the byte buffer
//   is free, is then merged into the buffer, and its first byte is valid on m_axis.
// Throughput: one request per cycle when it completes at most one byte and
//   m_axis_tready is high; a request that completes several bytes holds the byte
//   buffer until they drain through the single byte port at one byte per cycle
//   while m_axis_tready is high (up to 4 bytes for a 32-bit field).
// Reset: clears the bit position, partial byte, input valid flag and byte count.
// Stall: while m_axis_tready is low the buffer holds its bytes, one more request
//   waits in the input register, and s_axis_tready drops after that.
module msb_first_bit_field_packer_unit #(
    parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] mode, [7:2] width, [39:8] field_value
    input  logic [mfbp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_byte
    output logic [mfbp_pkg::BYTE_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast
);
    import mfbp_pkg::*;

    `include "msb_first_bit_field_packer_unit_macros.svh"

    localparam int LIMIT = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;
    localparam int NB    = (LIMIT + 7) / 8;
    localparam int CNT_W = $clog2(NB + 1);

    logic                     r_in_valid;
    t_mode                    r_in_mode;
    logic [WIDTH_W-1:0]       r_in_width;
    logic [VALUE_W-1:0]       r_in_value;
    t_pack_state              r_state;
    logic [NB-1:0][BYTE_W-1:0] r_buf;
    logic [CNT_W-1:0]         r_rem;

    t_pack_state              n_state;
    logic [CNT_W-1:0]         n_count;
    logic [NB-1:0][BYTE_W-1:0] n_bytes;

    logic in_fire;
    logic out_fire;
    logic buf_free;
    logic load;

    mfbp_packer #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_packer (
        .i_mode  (r_in_mode),
        .i_width (r_in_width),
        .i_value (r_in_value),
        .i_state (r_state),
        .o_state (n_state),
        .o_count (n_count),
        .o_bytes (n_bytes)
    );

    assign m_axis_tvalid = (r_rem != '0);
    assign m_axis_tdata  = r_buf[0];
    assign m_axis_tlast  = (r_rem == CNT_W'(1));
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign buf_free      = (r_rem == '0) || (r_rem == CNT_W'(1) && out_fire);
    assign load          = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || load;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_rem      <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_state <= n_state;
                r_rem   <= n_count;
            end else if (out_fire) begin
                r_rem   <= r_rem - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode  <= t_mode'(s_axis_tdata[MODE_W-1:0]);
            r_in_width <= s_axis_tdata[MODE_W +: WIDTH_W];
            r_in_value <= s_axis_tdata[MODE_W+WIDTH_W +: VALUE_W];
        end
        if (load) begin
            r_buf <= n_bytes;
        end else if (out_fire) begin
            r_buf <= r_buf >> BYTE_W;
        end
    end

    `MFBP_ASSERT_NOW(a_rem_bound, 1'b1, r_rem <= CNT_W'(NB), "byte count exceeds buffer")
    `MFBP_ASSERT_NOW(a_partial_clean, r_state.bit_pos == '0, r_state.partial == '0, "stale partial bits")
    `MFBP_ASSERT_NEXT(a_drain_cont, out_fire && r_rem > CNT_W'(1), m_axis_tvalid, "burst broken")
    `MFBP_ASSERT_NEXT(a_in_hold, r_in_valid && !load, r_in_valid && $stable(r_in_value), "request lost")

endmodule
